// File: hw/rtl/baro_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, constants and helper functions for the compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package baro_pkg;

    localparam int CalWidth   = 64;
    localparam int OssWidth   = 2;
    localparam int UtWidth    = 16;
    localparam int UpWidth    = 19;
    localparam int TempWidth  = 28;
    localparam int PresWidth  = 32;
    localparam int CfgIdxWidth = 2;
    localparam int DivSteps   = 32;
    localparam int DivStepsPerStage = 4;

    localparam logic [CfgIdxWidth-1:0] CFG_CAL_A = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_CAL_B = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CAL_C = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_OSS   = 2'd3;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] B4_OFFSET   = 32'd32768;
    localparam logic [31:0] P_COEF_SQ   = 32'd3038;
    localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_OFFSET    = 32'd3791;

    // State of an unsigned 32-bit restoring division, advanced one step by div_step.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
    } div_state_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
        asr32 = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic div_state_t div_step(input div_state_t s);
        div_state_t r;
        logic [32:0] trial;
        r = s;
        trial = {s.rem, s.quo[31]} - {1'b0, s.den};
        r.quo = {s.quo[30:0], ~trial[32]};
        r.rem = trial[32] ? {s.rem[30:0], s.quo[31]} : trial[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/baro_udiv.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring 32-bit divider, StepsPerStage quotient bits per register stage.
// Sideband data travels alongside. Stalls freeze every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_udiv #(
    parameter int SideWidth = 8,
    parameter int StepsPerStage = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [31:0]          num,
    input  wire logic [31:0]          den,
    input  wire logic [SideWidth-1:0] side_in,
    output logic                      out_valid,
    output logic [31:0]               quo,
    output logic [SideWidth-1:0]      side_out
);
    import baro_pkg::*;

    localparam int Stages = DivSteps / StepsPerStage;

    div_state_t                 st_reg   [Stages];
    logic [SideWidth-1:0]       side_reg [Stages];
    logic [Stages-1:0]          vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < Stages; s++)
            begin
                div_state_t t;
                if (s == 0)
                begin
                    t.rem = '0;
                    t.quo = num;
                    t.den = den;
                    side_reg[0] <= side_in;
                end
                else
                begin
                    t = st_reg[s-1];
                    side_reg[s] <= side_reg[s-1];
                end
                for (int k = 0; k < StepsPerStage; k++)
                begin
                    t = div_step(t);
                end
                st_reg[s] <= t;
            end
        end
    end

    assign out_valid = vld_reg[Stages-1];
    assign quo       = st_reg[Stages-1].quo;
    assign side_out  = side_reg[Stages-1];

endmodule

`default_nettype wire

// File: hw/rtl/barometer_compensation_core.sv
// Path: stage 1, temperature divider, stages 2 to 5, pressure divider, stages 6 and 7, output register.
// Throughput: one item per cycle while not stalled; two dividers of 8 stages each set most of the depth.
// A stall on the output freezes the whole pipeline; the output register keeps
// the waiting result, and input is taken only while the pipe advances.
// Reset (rst_n, asynchronous) clears valid bits and configuration to zero.
// ----------------------------------------------------------------------------
// Barometer compensation core
// Integer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module barometer_compensation_core #(
    parameter int StepsPerStage = baro_pkg::DivStepsPerStage
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [baro_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [baro_pkg::CalWidth-1:0]      cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // temp_raw [15:0], pres_raw [34:16], zero fill [39:35]
    input  wire logic [39:0]                        s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // temperature_tenths [27:0], pressure_pa [59:28], zero fill [63:60]
    output logic [63:0]                             m_tdata,
    // calc_error
    output logic                                    m_tuser
);
    import baro_pkg::*;

    logic [63:0] cal_a_reg, cal_b_reg, cal_c_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAL_A: cal_a_reg <= cfg_data;
                CFG_CAL_B: cal_b_reg <= cfg_data;
                CFG_CAL_C: cal_c_reg <= cfg_data;
                CFG_OSS:   oss_reg   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    wire logic [31:0] ac1 = sx16(cal_a_reg[63:48]);
    wire logic [31:0] ac2 = sx16(cal_a_reg[47:32]);
    wire logic [31:0] ac3 = sx16(cal_a_reg[31:16]);
    wire logic [31:0] ac4 = {16'd0, cal_a_reg[15:0]};
    wire logic [31:0] ac5 = {16'd0, cal_b_reg[63:48]};
    wire logic [31:0] ac6 = {16'd0, cal_b_reg[47:32]};
    wire logic [31:0] b1  = sx16(cal_b_reg[31:16]);
    wire logic [31:0] b2  = sx16(cal_b_reg[15:0]);
    wire logic [31:0] mc  = sx16(cal_c_reg[47:32]);
    wire logic [31:0] md  = sx16(cal_c_reg[31:16]);

    // The pipe advances whenever the output register is free or being taken.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    wire logic in_fire = s_tvalid && en;

    // Stage 1: x1 and temperature divisor.
    logic        v1_reg;
    logic [31:0] x1_1_reg, den1_reg, up1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= in_fire;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [31:0] x1;
            x1 = asr32(({16'd0, s_tdata[15:0]} - ac6) * ac5, 15);
            x1_1_reg <= x1;
            den1_reg <= x1 + md;
            up1_reg  <= {13'd0, s_tdata[34:16]};
        end
    end

    // Signed division mc<<11 / den through the unsigned divider.
    typedef struct packed {
        logic [31:0] x1;
        logic [31:0] up;
        logic        neg;
        logic        err;
    } td_side_t;

    wire logic [31:0] tnum = mc << 11;
    wire logic tden_zero   = den1_reg == 32'd0;
    wire logic [31:0] tma  = tnum[31] ? 32'd0 - tnum : tnum;
    wire logic [31:0] tmb  = den1_reg[31] ? 32'd0 - den1_reg : den1_reg;
    td_side_t tside_in, tside_out;
    logic        tq_valid;
    logic [31:0] tq;
    assign tside_in = '{x1: x1_1_reg, up: up1_reg, neg: tnum[31] ^ den1_reg[31],
                        err: tden_zero};

    baro_udiv #(.SideWidth($bits(td_side_t)), .StepsPerStage(StepsPerStage)) u_tdiv (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1_reg),
        .num(tma), .den(tden_zero ? 32'd1 : tmb), .side_in(tside_in),
        .out_valid(tq_valid), .quo(tq), .side_out(tside_out)
    );

    // Stage 2: b5, b6, b6 squared.
    logic        v2_reg;
    logic [31:0] b5_2_reg, b6_2_reg, sq_2_reg, up2_reg;
    logic        err2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= tq_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [31:0] x2, b5, b6;
            x2 = tside_out.neg ? 32'd0 - tq : tq;
            b5 = tside_out.x1 + x2;
            b6 = b5 - B6_OFFSET;
            b5_2_reg <= b5;
            b6_2_reg <= b6;
            sq_2_reg <= 32'(b6 * b6);
            up2_reg  <= tside_out.up;
            err2_reg <= tside_out.err;
        end
    end

    // Stage 3: products with b6 and b6sq.
    logic        v3_reg;
    logic [31:0] b5_3_reg, up3_reg, p1_reg, p2_reg, p3_reg, p4_reg;
    logic        err3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [31:0] sq;
            sq = asr32(sq_2_reg, 12);
            p1_reg   <= asr32(b2 * sq, 11);
            p2_reg   <= asr32(ac2 * b6_2_reg, 11);
            p3_reg   <= asr32(ac3 * b6_2_reg, 13);
            p4_reg   <= asr32(b1 * sq, 16);
            b5_3_reg <= b5_2_reg;
            up3_reg  <= up2_reg;
            err3_reg <= err2_reg;
        end
    end

    // Stage 4: b3 and the b4 product.
    logic        v4_reg;
    logic [31:0] b5_4_reg, up4_reg, b3_reg, b4p_reg;
    logic        err4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [31:0] n, x3;
            n  = ((ac1 * 32'd4 + p1_reg + p2_reg) << oss_reg) + 32'd2;
            // Truncating divide by four.
            b3_reg  <= asr32(n + (n[31] ? 32'd3 : 32'd0), 2);
            x3      = asr32(p3_reg + p4_reg + 32'd2, 2);
            b4p_reg <= ac4 * (x3 + B4_OFFSET);
            b5_4_reg <= b5_3_reg;
            up4_reg  <= up3_reg;
            err4_reg <= err3_reg;
        end
    end

    // Stage 5: b4 and b7.
    logic        v5_reg;
    logic [31:0] b5_5_reg, b4_reg, b7_reg;
    logic        err5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4_reg   <= b4p_reg >> 15;
            b7_reg   <= (up4_reg - b3_reg) * (B7_SCALE >> oss_reg);
            b5_5_reg <= b5_4_reg;
            err5_reg <= err4_reg;
        end
    end

    typedef struct packed {
        logic [31:0] b5;
        logic        dbl;
        logic        err;
    } pd_side_t;

    wire logic pden_zero = b4_reg == 32'd0;
    wire logic small_b7  = !b7_reg[31];
    pd_side_t pside_in, pside_out;
    logic        pq_valid;
    logic [31:0] pq;
    assign pside_in = '{b5: b5_5_reg, dbl: !small_b7, err: err5_reg || pden_zero};

    baro_udiv #(.SideWidth($bits(pd_side_t)), .StepsPerStage(StepsPerStage)) u_pdiv (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .num(small_b7 ? b7_reg << 1 : b7_reg), .den(pden_zero ? 32'd1 : b4_reg),
        .side_in(pside_in), .out_valid(pq_valid), .quo(pq), .side_out(pside_out)
    );

    // Stage 6: p and its shifted square.
    logic        v6_reg;
    logic [31:0] p6_reg, ps_reg, b5_6_reg;
    logic        err6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else if (en) v6_reg <= pq_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [31:0] p;
            p = pside_out.dbl ? pq << 1 : pq;
            p6_reg   <= p;
            ps_reg   <= asr32(p, 8) * asr32(p, 8);
            b5_6_reg <= pside_out.b5;
            err6_reg <= pside_out.err;
        end
    end

    // Stage 7: correction products.
    logic        v7_reg;
    logic [31:0] p7_reg, c1_reg, c2_reg, b5_7_reg;
    logic        err7_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v7_reg <= 1'b0;
        else if (en) v7_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= asr32(ps_reg * P_COEF_SQ, 16);
            c2_reg   <= asr32(P_COEF_LIN * p6_reg, 16);
            p7_reg   <= p6_reg;
            b5_7_reg <= b5_6_reg;
            err7_reg <= err6_reg;
        end
    end

    // Output register.
    logic [27:0] t_reg;
    logic [31:0] p_reg;
    logic        e_reg, ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (en) ov_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [31:0] t, p;
            t = asr32(b5_7_reg + 32'd8, 4);
            p = p7_reg + asr32(c1_reg + c2_reg + P_OFFSET, 4);
            t_reg <= err7_reg ? 28'd0 : t[27:0];
            p_reg <= err7_reg ? 32'd0 : p;
            e_reg <= err7_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, p_reg, t_reg};
    assign m_tuser  = e_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[59:0] == 60'd0)
        else $error("error result not zeroed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("pipe stalled with free output");
`endif

endmodule

`default_nettype wire
